// ===== rtl/slr_pkg.sv =====
// Shared constants, types and arithmetic helpers of the SGD linear-regression engine.
`default_nettype none

package slr_pkg;

   localparam int MAX_FEATURES = 16;
   localparam int IDX_W        = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CNT_W        = $clog2(MAX_FEATURES + 1);

   localparam int FEAT_W     = 32;
   localparam int ACC_W      = 64;
   localparam int LR_W       = 32;
   localparam int FC_W       = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam int WEIGHT_INIT = 100;
   localparam int FC_RESET    = 16;

   localparam logic [ACC_W-1:0] WEIGHT_RESET = ACC_W'(WEIGHT_INIT) << 32;
   localparam logic [ACC_W-1:0] BIAS_RESET   = ACC_W'(1) << 32;
   localparam logic [LR_W-1:0]  LR_RESET     = LR_W'(429);
   localparam logic [CNT_W-1:0] COUNT_RESET  =
      CNT_W'((FC_RESET > MAX_FEATURES) ? MAX_FEATURES : FC_RESET);

   localparam logic [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [FEAT_W-1:0] S32_MAX = {1'b0, {(FEAT_W-1){1'b1}}};
   localparam logic [FEAT_W-1:0] S32_MIN = {1'b1, {(FEAT_W-1){1'b0}}};

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FEATURE_COUNT = CSR_IDX_W'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WMAG,
      ST_XMAG,
      ST_PMAG,
      ST_BMAG,
      ST_MLO,
      ST_MHI,
      ST_SUM,
      ST_SGN,
      ST_ACC,
      ST_TOT,
      ST_PRED,
      ST_RESID,
      ST_EMIT
   } state_type;

   // what the current multiply sequence serves
   typedef enum logic [1:0] {
      KIND_DOT,
      KIND_XR,
      KIND_WUPD,
      KIND_BUPD
   } kind_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LOAD,
      DP_MAG_WX,
      DP_MAG_XR,
      DP_MAG_PL,
      DP_MAG_BL,
      DP_MUL_LO,
      DP_MUL_HI,
      DP_SUM_WX,
      DP_SUM_LR,
      DP_SGN,
      DP_ACC_DOT,
      DP_UPD_W,
      DP_UPD_B,
      DP_TOT,
      DP_PRED,
      DP_RESID,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [IDX_W-1:0] idx;
      logic             clear_acc;
   } dp_cmd_type;

   function automatic logic [ACC_W-1:0] sat_add64(input logic [ACC_W-1:0] a,
                                                   input logic [ACC_W-1:0] b);
      logic [ACC_W-1:0] s;
      s = a + b;
      if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
         return a[ACC_W-1] ? S64_MIN : S64_MAX;
      end
      return s;
   endfunction

   function automatic logic [ACC_W-1:0] sat_sub64(input logic [ACC_W-1:0] a,
                                                   input logic [ACC_W-1:0] b);
      logic [ACC_W-1:0] s;
      s = a - b;
      if ((a[ACC_W-1] != b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
         return a[ACC_W-1] ? S64_MIN : S64_MAX;
      end
      return s;
   endfunction

   // narrow a signed 48-bit value to 32 bits with saturation
   function automatic logic [FEAT_W-1:0] sat32(input logic [47:0] v);
      if (!v[47] && (|v[46:31])) begin
         return S32_MAX;
      end
      if (v[47] && !(&v[46:31])) begin
         return S32_MIN;
      end
      return v[31:0];
   endfunction

   function automatic logic [FEAT_W-1:0] abs32(input logic [FEAT_W-1:0] v);
      return v[FEAT_W-1] ? (~v + FEAT_W'(1)) : v;
   endfunction

   function automatic logic [ACC_W-1:0] abs64(input logic [ACC_W-1:0] v);
      return v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/slr_csr.sv =====
// Configuration registers: learning rate and clamped feature count.
`default_nettype none

module slr_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [slr_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [slr_pkg::CSR_DATA_W-1:0]         csr_data,
   output logic [slr_pkg::LR_W-1:0]               step_size,
   output logic [slr_pkg::CNT_W-1:0]              feature_count,
   output logic                                   count_clear
);

   logic [slr_pkg::LR_W-1:0]  lr_ff, lr_in;
   logic [slr_pkg::CNT_W-1:0] count_ff, count_in;
   logic [slr_pkg::FC_W-1:0]  raw_count;
   logic                      wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;
   assign raw_count = csr_data[slr_pkg::FC_W-1:0];

   always_comb begin
      lr_in       = lr_ff;
      count_in    = count_ff;
      count_clear = 1'b0;
      if (wr) begin
         unique case (csr_index)
            slr_pkg::CSR_STEP_SIZE: begin
               lr_in = csr_data[slr_pkg::LR_W-1:0];
            end
            slr_pkg::CSR_FEATURE_COUNT: begin
               // clamp to 1..MAX_FEATURES and drop any partial sample
               count_clear = 1'b1;
               if (raw_count == '0) begin
                  count_in = slr_pkg::CNT_W'(1);
               end else if (int'(raw_count) > slr_pkg::MAX_FEATURES) begin
                  count_in = slr_pkg::CNT_W'(slr_pkg::MAX_FEATURES);
               end else begin
                  count_in = slr_pkg::CNT_W'(raw_count);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff    <= slr_pkg::LR_RESET;
         count_ff <= slr_pkg::COUNT_RESET;
      end else begin
         lr_ff    <= lr_in;
         count_ff <= count_in;
      end
   end

   assign step_size     = lr_ff;
   assign feature_count = count_ff;

endmodule

`default_nettype wire

// ===== rtl/slr_ctrl.sv =====
// Sequencer for the feature walk, sample finish and weight-update walk.
`default_nettype none

module slr_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         req_func,
   input  logic [slr_pkg::CNT_W-1:0]    feature_count,
   input  logic                         count_clear,
   input  logic                         out_hold,
   output slr_pkg::dp_cmd_type          cmd
);

   slr_pkg::state_type         state_ff, state_in;
   slr_pkg::kind_type          kind_ff, kind_in;
   logic [slr_pkg::IDX_W-1:0]  fidx_ff, fidx_in;
   logic [slr_pkg::IDX_W-1:0]  uidx_ff, uidx_in;
   logic                       last_ff, last_in;
   logic                       train_ff, train_in;
   logic [slr_pkg::IDX_W-1:0]  cur_idx;
   logic                       cur_last;
   logic                       uidx_last;
   logic                       accept;

   always_comb begin
      cur_idx   = (slr_pkg::CNT_W'(fidx_ff) >= feature_count) ? '0 : fidx_ff;
      cur_last  = (slr_pkg::CNT_W'(cur_idx) + slr_pkg::CNT_W'(1)) == feature_count;
      uidx_last = (slr_pkg::CNT_W'(uidx_ff) + slr_pkg::CNT_W'(1)) == feature_count;
      accept    = req_tvalid & req_tready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         slr_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = slr_pkg::ST_WMAG;
               kind_in  = slr_pkg::KIND_DOT;
            end
         end
         slr_pkg::ST_WMAG:  state_in = slr_pkg::ST_MLO;
         slr_pkg::ST_XMAG:  state_in = slr_pkg::ST_MLO;
         slr_pkg::ST_PMAG: begin
            state_in = slr_pkg::ST_MLO;
            kind_in  = slr_pkg::KIND_WUPD;
         end
         slr_pkg::ST_BMAG: begin
            state_in = slr_pkg::ST_MLO;
            kind_in  = slr_pkg::KIND_BUPD;
         end
         slr_pkg::ST_MLO: begin
            // feature times residual needs one pass only, then scale by lr
            state_in = (kind_ff == slr_pkg::KIND_XR) ? slr_pkg::ST_PMAG : slr_pkg::ST_MHI;
         end
         slr_pkg::ST_MHI:   state_in = slr_pkg::ST_SUM;
         slr_pkg::ST_SUM:   state_in = slr_pkg::ST_SGN;
         slr_pkg::ST_SGN:   state_in = slr_pkg::ST_ACC;
         slr_pkg::ST_ACC: begin
            unique case (kind_ff)
               slr_pkg::KIND_DOT: begin
                  state_in = last_ff ? slr_pkg::ST_TOT : slr_pkg::ST_IDLE;
               end
               slr_pkg::KIND_WUPD: begin
                  if (uidx_last) begin
                     state_in = slr_pkg::ST_BMAG;
                  end else begin
                     state_in = slr_pkg::ST_XMAG;
                     kind_in  = slr_pkg::KIND_XR;
                  end
               end
               default: state_in = slr_pkg::ST_IDLE;
            endcase
         end
         slr_pkg::ST_TOT:   state_in = slr_pkg::ST_PRED;
         slr_pkg::ST_PRED:  state_in = slr_pkg::ST_RESID;
         slr_pkg::ST_RESID: state_in = slr_pkg::ST_EMIT;
         slr_pkg::ST_EMIT: begin
            if (!out_hold) begin
               if (train_ff) begin
                  state_in = slr_pkg::ST_XMAG;
                  kind_in  = slr_pkg::KIND_XR;
               end else begin
                  state_in = slr_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = slr_pkg::ST_IDLE;
      endcase
   end

   // indexes and sample flags
   always_comb begin
      fidx_in  = fidx_ff;
      uidx_in  = uidx_ff;
      last_in  = last_ff;
      train_in = train_ff;
      if (accept) begin
         last_in  = cur_last;
         train_in = ~req_func;
         fidx_in  = cur_last ? '0 : (cur_idx + slr_pkg::IDX_W'(1));
      end
      if (count_clear) begin
         fidx_in = '0;
      end
      if ((state_ff == slr_pkg::ST_EMIT) && !out_hold) begin
         uidx_in = '0;
      end
      if ((state_ff == slr_pkg::ST_ACC) && (kind_ff == slr_pkg::KIND_WUPD) && !uidx_last) begin
         uidx_in = uidx_ff + slr_pkg::IDX_W'(1);
      end
   end

   // outputs
   always_comb begin
      req_tready    = (state_ff == slr_pkg::ST_IDLE);
      cmd.op        = slr_pkg::DP_NOP;
      cmd.idx       = (state_ff == slr_pkg::ST_IDLE) ? cur_idx : uidx_ff;
      cmd.clear_acc = count_clear;
      unique case (state_ff)
         slr_pkg::ST_IDLE:  cmd.op = req_tvalid ? slr_pkg::DP_LOAD : slr_pkg::DP_NOP;
         slr_pkg::ST_WMAG:  cmd.op = slr_pkg::DP_MAG_WX;
         slr_pkg::ST_XMAG:  cmd.op = slr_pkg::DP_MAG_XR;
         slr_pkg::ST_PMAG:  cmd.op = slr_pkg::DP_MAG_PL;
         slr_pkg::ST_BMAG:  cmd.op = slr_pkg::DP_MAG_BL;
         slr_pkg::ST_MLO:   cmd.op = slr_pkg::DP_MUL_LO;
         slr_pkg::ST_MHI:   cmd.op = slr_pkg::DP_MUL_HI;
         slr_pkg::ST_SUM: begin
            cmd.op = (kind_ff == slr_pkg::KIND_DOT) ? slr_pkg::DP_SUM_WX : slr_pkg::DP_SUM_LR;
         end
         slr_pkg::ST_SGN:   cmd.op = slr_pkg::DP_SGN;
         slr_pkg::ST_ACC: begin
            unique case (kind_ff)
               slr_pkg::KIND_DOT:  cmd.op = slr_pkg::DP_ACC_DOT;
               slr_pkg::KIND_WUPD: cmd.op = slr_pkg::DP_UPD_W;
               slr_pkg::KIND_BUPD: cmd.op = slr_pkg::DP_UPD_B;
               default:            cmd.op = slr_pkg::DP_NOP;
            endcase
         end
         slr_pkg::ST_TOT:   cmd.op = slr_pkg::DP_TOT;
         slr_pkg::ST_PRED:  cmd.op = slr_pkg::DP_PRED;
         slr_pkg::ST_RESID: cmd.op = slr_pkg::DP_RESID;
         slr_pkg::ST_EMIT:  cmd.op = out_hold ? slr_pkg::DP_NOP : slr_pkg::DP_EMIT;
         default:           cmd.op = slr_pkg::DP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slr_pkg::ST_IDLE;
         kind_ff  <= slr_pkg::KIND_DOT;
         fidx_ff  <= '0;
         uidx_ff  <= '0;
         last_ff  <= 1'b0;
         train_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         fidx_ff  <= fidx_in;
         uidx_ff  <= uidx_in;
         last_ff  <= last_in;
         train_ff <= train_in;
      end
   end

   ast_accept_starts_mac: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == slr_pkg::ST_WMAG))
      else $error("accepted transaction did not start the multiply-accumulate");

   ast_fidx_range: assert property (@(posedge clock) disable iff (reset)
      slr_pkg::CNT_W'(fidx_ff) < feature_count)
      else $error("feature index beyond feature count");

   ast_update_only_train: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == slr_pkg::ST_ACC) && (kind_ff == slr_pkg::KIND_WUPD)) |-> train_ff)
      else $error("weight update outside a training sample");

endmodule

`default_nettype wire

// ===== rtl/slr_dp.sv =====
// Datapath: weight and feature stores, shared 32x32 multiplier, saturating sums, result register.
`default_nettype none

module slr_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  slr_pkg::dp_cmd_type           cmd,
   input  logic [slr_pkg::LR_W-1:0]      step_size,
   input  logic [slr_pkg::FEAT_W-1:0]    feature_value,
   input  logic [slr_pkg::FEAT_W-1:0]    target_value,
   output logic                          out_hold,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [2*slr_pkg::FEAT_W-1:0]  rsp_tdata
);

   logic [slr_pkg::FEAT_W-1:0] feat_ff [slr_pkg::MAX_FEATURES];
   logic [slr_pkg::ACC_W-1:0]  wt_ff   [slr_pkg::MAX_FEATURES];

   logic [slr_pkg::FEAT_W-1:0] x_ff, x_in, tgt_ff, tgt_in;
   logic [slr_pkg::ACC_W-1:0]  w_ff, w_in;
   logic [slr_pkg::ACC_W-1:0]  bias_ff, bias_in, acc_ff, acc_in;
   logic [slr_pkg::ACC_W-1:0]  mag_a_ff, mag_a_in;
   logic [slr_pkg::LR_W-1:0]   mag_b_ff, mag_b_in;
   logic                       neg_ff, neg_in;
   logic [slr_pkg::ACC_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, q_ff, q_in;
   logic                       ovf_ff, ovf_in, rnd_ff, rnd_in;
   logic [slr_pkg::ACC_W-1:0]  term_ff, term_in, total_ff, total_in;
   logic [slr_pkg::FEAT_W-1:0] pred_ff, pred_in, resid_ff, resid_in;
   logic                       out_valid_ff, out_valid_in;
   logic [2*slr_pkg::FEAT_W-1:0] out_data_ff, out_data_in;

   logic [slr_pkg::FEAT_W-1:0] feat_sel, abs_x, abs_feat, abs_resid, mul_a;
   logic [slr_pkg::ACC_W-1:0]  abs_w, wt_sel, wt_new, mul_p, q_wx, q_lr;
   logic [slr_pkg::FEAT_W:0]   diff;
   logic                       q_big;

   always_comb begin
      abs_w     = slr_pkg::abs64(w_ff);
      abs_x     = slr_pkg::abs32(x_ff);
      feat_sel  = feat_ff[cmd.idx];
      abs_feat  = slr_pkg::abs32(feat_sel);
      abs_resid = slr_pkg::abs32(resid_ff);
      wt_sel    = wt_ff[cmd.idx];
      wt_new    = slr_pkg::sat_sub64(wt_sel, term_ff);
      mul_a     = (cmd.op == slr_pkg::DP_MUL_HI) ? mag_a_ff[63:32] : mag_a_ff[31:0];
      mul_p     = mul_a * mag_b_ff;
      // weight times feature keeps 16 fraction bits less; lr scaling drops 32
      q_wx      = {hi_ff[47:0], 16'b0} + {16'b0, lo_ff[63:16]};
      q_lr      = hi_ff + {32'b0, lo_ff[63:32]};
      q_big     = q_ff[63] | (rnd_ff & (q_ff == slr_pkg::S64_MAX));
      diff      = {pred_ff[31], pred_ff} - {tgt_ff[31], tgt_ff};

      x_in         = x_ff;
      tgt_in       = tgt_ff;
      w_in         = w_ff;
      bias_in      = bias_ff;
      acc_in       = acc_ff;
      mag_a_in     = mag_a_ff;
      mag_b_in     = mag_b_ff;
      neg_in       = neg_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      q_in         = q_ff;
      ovf_in       = ovf_ff;
      rnd_in       = rnd_ff;
      term_in      = term_ff;
      total_in     = total_ff;
      pred_in      = pred_ff;
      resid_in     = resid_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;

      unique case (cmd.op)
         slr_pkg::DP_LOAD: begin
            x_in   = feature_value;
            tgt_in = target_value;
            w_in   = wt_sel;
         end
         slr_pkg::DP_MAG_WX: begin
            mag_a_in = abs_w;
            mag_b_in = abs_x;
            neg_in   = w_ff[63] ^ x_ff[31];
         end
         slr_pkg::DP_MAG_XR: begin
            mag_a_in = {32'b0, abs_feat};
            mag_b_in = abs_resid;
            neg_in   = feat_sel[31] ^ resid_ff[31];
         end
         slr_pkg::DP_MAG_PL: begin
            // feature times residual magnitude, now scaled by lr
            mag_a_in = lo_ff;
            mag_b_in = step_size;
         end
         slr_pkg::DP_MAG_BL: begin
            mag_a_in = {16'b0, abs_resid, 16'b0};
            mag_b_in = step_size;
            neg_in   = resid_ff[31];
         end
         slr_pkg::DP_MUL_LO: lo_in = mul_p;
         slr_pkg::DP_MUL_HI: hi_in = mul_p;
         slr_pkg::DP_SUM_WX: begin
            q_in   = q_wx;
            ovf_in = |hi_ff[63:47];
            rnd_in = |lo_ff[15:0];
         end
         slr_pkg::DP_SUM_LR: begin
            q_in   = q_lr;
            ovf_in = 1'b0;
            rnd_in = |lo_ff[31:0];
         end
         slr_pkg::DP_SGN: begin
            // negative results floor: -(q + 1) when fraction bits were dropped
            if (ovf_ff) begin
               term_in = neg_ff ? slr_pkg::S64_MIN : slr_pkg::S64_MAX;
            end else if (!neg_ff) begin
               term_in = q_ff[63] ? slr_pkg::S64_MAX : q_ff;
            end else if (q_big) begin
               term_in = slr_pkg::S64_MIN;
            end else begin
               term_in = ~q_ff + {63'b0, ~rnd_ff};
            end
         end
         slr_pkg::DP_ACC_DOT: acc_in   = slr_pkg::sat_add64(acc_ff, term_ff);
         slr_pkg::DP_UPD_B:   bias_in  = slr_pkg::sat_sub64(bias_ff, term_ff);
         slr_pkg::DP_TOT:     total_in = slr_pkg::sat_add64(acc_ff, bias_ff);
         slr_pkg::DP_PRED:    pred_in  = slr_pkg::sat32(total_ff[63:16]);
         slr_pkg::DP_RESID:   resid_in = slr_pkg::sat32({{15{diff[32]}}, diff});
         slr_pkg::DP_EMIT: begin
            out_data_in  = {resid_ff, pred_ff};
            out_valid_in = 1'b1;
            acc_in       = '0;
         end
         default: begin
         end
      endcase

      if (cmd.clear_acc) begin
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < slr_pkg::MAX_FEATURES; i++) begin
            wt_ff[i] <= slr_pkg::WEIGHT_RESET;
         end
         bias_ff      <= slr_pkg::BIAS_RESET;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == slr_pkg::DP_UPD_W) begin
            wt_ff[cmd.idx] <= wt_new;
         end
         bias_ff      <= bias_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == slr_pkg::DP_LOAD) begin
         feat_ff[cmd.idx] <= feature_value;
      end
      x_ff        <= x_in;
      tgt_ff      <= tgt_in;
      w_ff        <= w_in;
      mag_a_ff    <= mag_a_in;
      mag_b_ff    <= mag_b_in;
      neg_ff      <= neg_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      q_ff        <= q_in;
      ovf_ff      <= ovf_in;
      rnd_ff      <= rnd_in;
      term_ff     <= term_in;
      total_ff    <= total_in;
      pred_ff     <= pred_in;
      resid_ff    <= resid_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign out_hold   = out_valid_ff & ~rsp_tready;

   ast_emit_shows_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == slr_pkg::DP_EMIT) |=> (rsp_tvalid && (acc_ff == '0)))
      else $error("finished sample not presented or accumulator not cleared");

   ast_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == slr_pkg::DP_EMIT) |-> !out_hold)
      else $error("result register overwritten while a transaction waits");

endmodule

`default_nettype wire

// ===== rtl/sgd_linear_regression.sv =====
// Online linear-regression engine with SGD training: top level.
// Each request transaction carries one Q16.16 feature; after feature_count features the
// engine returns one response transaction holding the saturated prediction (weights times
// features plus bias) and residual (prediction minus the target of the last transaction).
// When the last transaction's tuser bit is 0, every weight and the bias then move by
// lr*x*residual and lr*residual before the next request is taken. All work runs on one
// shared 32x32 multiplier driven by a sequencer: each feature is multiplied and
// accumulated before the next is accepted, the last feature of a sample also forms and
// registers the result (waiting while the response register is still full), and training
// then walks the update over every weight and the bias. Weights reset to 100.0 and the
// bias to 1.0; writing feature_count discards any partial sample.
`default_nettype none

module sgd_linear_regression (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [2*slr_pkg::FEAT_W-1:0]         req_tdata,  // feature_value, target_value
   input  logic                                 req_tuser,  // func
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [2*slr_pkg::FEAT_W-1:0]         rsp_tdata,  // prediction, residual
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [slr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [slr_pkg::CSR_DATA_W-1:0]       csr_data
);

   logic [slr_pkg::LR_W-1:0]  step_size;
   logic [slr_pkg::CNT_W-1:0] feature_count;
   logic                      count_clear;
   logic                      out_hold;
   slr_pkg::dp_cmd_type       cmd;

   slr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .step_size     (step_size),
      .feature_count (feature_count),
      .count_clear   (count_clear)
   );

   slr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_func      (req_tuser),
      .feature_count (feature_count),
      .count_clear   (count_clear),
      .out_hold      (out_hold),
      .cmd           (cmd)
   );

   slr_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .step_size     (step_size),
      .feature_value (req_tdata[slr_pkg::FEAT_W-1:0]),
      .target_value  (req_tdata[2*slr_pkg::FEAT_W-1:slr_pkg::FEAT_W]),
      .out_hold      (out_hold),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

`default_nettype wire
